// ----- design/rip_pkg.sv -----
package rip_pkg;

    typedef enum logic [2:0] {
        ST_OK        = 3'd0,
        ST_BAD_RADIX = 3'd1,
        ST_MALFORMED = 3'd2,
        ST_BAD_DIGIT = 3'd3,
        ST_OVERFLOW  = 3'd4,
        ST_RANGE     = 3'd5
    } status_t;

    typedef enum logic [1:0] {
        REG_RADIX        = 2'd0,
        REG_RESULT_WIDTH = 2'd1
    } reg_index_t;

    typedef enum logic [1:0] {
        WIDTH_8  = 2'd0,
        WIDTH_16 = 2'd1,
        WIDTH_32 = 2'd2,
        WIDTH_64 = 2'd3
    } width_code_t;

    localparam logic [20:0] CH_MINUS = 21'h2D;
    localparam logic [20:0] CH_PLUS  = 21'h2B;
    localparam logic [20:0] CH_ZERO  = 21'h30;

    localparam logic [5:0] RADIX_MIN   = 6'd2;
    localparam logic [5:0] RADIX_MAX   = 6'd36;
    localparam logic [5:0] RADIX_RESET = 6'd10;
    localparam logic [6:0] NO_DIGIT    = 7'd99;

    // lower bounds of the negative accumulator, widened for the multiply-subtract
    localparam logic signed [71:0] LIMIT64_NEG = {{9{1'b1}}, 63'd0};
    localparam logic signed [71:0] LIMIT64_POS = LIMIT64_NEG + 72'sd1;
    localparam logic signed [71:0] LIMIT32_NEG = {{41{1'b1}}, 31'd0};
    localparam logic signed [71:0] LIMIT32_POS = LIMIT32_NEG + 72'sd1;

    localparam logic signed [63:0] I32_MIN = -64'sd2147483648;
    localparam logic signed [63:0] I32_MAX = 64'sd2147483647;
    localparam logic signed [63:0] I16_MIN = -64'sd32768;
    localparam logic signed [63:0] I16_MAX = 64'sd32767;
    localparam logic signed [63:0] I8_MIN  = -64'sd128;
    localparam logic signed [63:0] I8_MAX  = 64'sd127;

    typedef struct packed {
        logic [20:0] char_code;
        logic        last_char;
        logic        empty_text;
    } in_item_t;

    typedef struct packed {
        logic signed [63:0] parsed_value;
        logic [2:0]         parse_status;
    } out_item_t;

    typedef struct packed {
        logic [5:0] radix;
        logic [1:0] result_width;
    } cfg_t;

    // parse state at the end of a string, handed to the finishing stage
    typedef struct packed {
        logic signed [63:0] acc;
        logic               is_negative;
        logic               digit_seen;
        status_t            error_code;
        logic               radix_ok;
        logic [1:0]         result_width;
    } end_rec_t;

    function automatic logic [6:0] digit_value(input logic [20:0] c);
        logic [6:0] v;
        v = NO_DIGIT;
        if (c >= 21'h30 && c <= 21'h39)
        begin
            v = 7'(c - 21'h30);
        end
        else if (c >= 21'h61 && c <= 21'h7A)
        begin
            v = 7'(c - 21'h61 + 21'd10);
        end
        else if (c >= 21'h41 && c <= 21'h5A)
        begin
            v = 7'(c - 21'h41 + 21'd10);
        end
        return v;
    endfunction

endpackage

// ----- design/rip_step.sv -----
module rip_step
    import rip_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  cfg_t     cfg,
    input  logic     item_valid,
    output logic     item_ready,
    input  in_item_t item,
    output logic     end_valid,
    input  logic     end_ready,
    output end_rec_t end_rec
);

    logic signed [63:0] acc_reg, acc_next;
    logic               neg_reg, neg_next;
    logic               first_reg, first_next;
    logic               seen_reg, seen_next;
    status_t            err_reg, err_next;
    logic               end_valid_reg, end_valid_next;
    end_rec_t           end_rec_reg;

    logic signed [63:0] upd_acc;
    logic               upd_neg;
    logic               upd_first;
    logic               upd_seen;
    status_t            upd_err;

    logic               radix_ok;
    logic [6:0]         digit;
    logic signed [71:0] acc_ext;
    logic signed [71:0] radix_ext;
    logic signed [71:0] prod;
    logic signed [71:0] cand;
    logic signed [71:0] limit;
    logic               ends;
    logic               take;

    assign radix_ok  = (cfg.radix >= RADIX_MIN) && (cfg.radix <= RADIX_MAX);
    assign digit     = digit_value(item.char_code);
    assign acc_ext   = {{8{acc_reg[63]}}, acc_reg};
    assign radix_ext = {66'd0, cfg.radix};
    assign prod      = acc_ext * radix_ext;
    assign cand      = prod - {65'd0, digit};
    assign ends      = item.empty_text || item.last_char;
    assign item_ready = !ends || !end_valid_reg || end_ready;
    assign take       = item_valid && item_ready;

    always_comb
    begin
        if (cfg.result_width == WIDTH_64)
        begin
            limit = neg_reg ? LIMIT64_NEG : LIMIT64_POS;
        end
        else
        begin
            limit = neg_reg ? LIMIT32_NEG : LIMIT32_POS;
        end
    end

    always_comb
    begin
        upd_acc   = acc_reg;
        upd_neg   = neg_reg;
        upd_first = first_reg;
        upd_seen  = seen_reg;
        upd_err   = err_reg;
        if (!item.empty_text)
        begin
            upd_first = 1'b0;
            if (!radix_ok)
            begin
                upd_err = ST_BAD_RADIX;
            end
            else if (err_reg == ST_OK)
            begin
                if (first_reg && item.char_code < CH_ZERO)
                begin
                    if (item.char_code == CH_MINUS)
                    begin
                        upd_neg = 1'b1;
                    end
                    else if (item.char_code != CH_PLUS)
                    begin
                        upd_err = ST_MALFORMED;
                    end
                end
                else if (digit >= {1'b0, cfg.radix})
                begin
                    upd_err = ST_BAD_DIGIT;
                end
                // acc*radix - digit below the limit covers both overflow checks
                else if (cand < limit)
                begin
                    upd_err = ST_OVERFLOW;
                end
                else
                begin
                    upd_acc  = cand[63:0];
                    upd_seen = 1'b1;
                end
            end
        end
    end

    always_comb
    begin
        acc_next       = acc_reg;
        neg_next       = neg_reg;
        first_next     = first_reg;
        seen_next      = seen_reg;
        err_next       = err_reg;
        end_valid_next = end_valid_reg;
        if (end_ready)
        begin
            end_valid_next = 1'b0;
        end
        if (take)
        begin
            if (ends)
            begin
                acc_next       = '0;
                neg_next       = 1'b0;
                first_next     = 1'b1;
                seen_next      = 1'b0;
                err_next       = ST_OK;
                end_valid_next = 1'b1;
            end
            else
            begin
                acc_next   = upd_acc;
                neg_next   = upd_neg;
                first_next = upd_first;
                seen_next  = upd_seen;
                err_next   = upd_err;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_reg       <= '0;
            neg_reg       <= 1'b0;
            first_reg     <= 1'b1;
            seen_reg      <= 1'b0;
            err_reg       <= ST_OK;
            end_valid_reg <= 1'b0;
        end
        else
        begin
            acc_reg       <= acc_next;
            neg_reg       <= neg_next;
            first_reg     <= first_next;
            seen_reg      <= seen_next;
            err_reg       <= err_next;
            end_valid_reg <= end_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take && ends)
        begin
            end_rec_reg.acc          <= upd_acc;
            end_rec_reg.is_negative  <= upd_neg;
            end_rec_reg.digit_seen   <= upd_seen;
            end_rec_reg.error_code   <= upd_err;
            end_rec_reg.radix_ok     <= radix_ok;
            end_rec_reg.result_width <= cfg.result_width;
        end
    end

    assign end_valid = end_valid_reg;
    assign end_rec   = end_rec_reg;

endmodule

// ----- design/rip_finish.sv -----
module rip_finish
    import rip_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      end_valid,
    output logic      end_ready,
    input  end_rec_t  end_rec,
    output logic      out_valid,
    input  logic      out_ready,
    output out_item_t out_data
);

    logic               out_valid_reg, out_valid_next;
    out_item_t          out_data_reg;
    logic signed [63:0] value;
    status_t            status;
    logic               take;

    assign end_ready = !out_valid_reg || out_ready;
    assign take      = end_valid && end_ready;

    always_comb
    begin
        value  = end_rec.is_negative ? end_rec.acc : -end_rec.acc;
        status = end_rec.error_code;
        if (!end_rec.radix_ok)
        begin
            status = ST_BAD_RADIX;
        end
        else if (status == ST_OK && !end_rec.digit_seen)
        begin
            status = ST_MALFORMED;
        end
        if (status == ST_OK)
        begin
            // width may have been narrowed mid-string, so recheck the 32-bit range
            if (end_rec.result_width != WIDTH_64 && (value < I32_MIN || value > I32_MAX))
            begin
                status = ST_OVERFLOW;
            end
            else if (end_rec.result_width == WIDTH_8 && (value < I8_MIN || value > I8_MAX))
            begin
                status = ST_RANGE;
            end
            else if (end_rec.result_width == WIDTH_16 &&
                     (value < I16_MIN || value > I16_MAX))
            begin
                status = ST_RANGE;
            end
        end
        if (status != ST_OK)
        begin
            value = '0;
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        if (take)
        begin
            out_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            out_data_reg.parsed_value <= value;
            out_data_reg.parse_status <= status;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule

// ----- design/radix_integer_parser.sv -----
// path: a character is registered at the input, an ended string's record in rip_step,
//   and its result in the output register of rip_finish
// throughput: one character per cycle while the output is not held off, set by the
//   multiply-subtract-compare that feeds the accumulator back on itself
// reset: asynchronous, active low; parse state cleared, radix 10, width int32
module radix_integer_parser
    import rip_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  in_item_t   in_data,
    output logic       out_valid,
    input  logic       out_ready,
    output out_item_t  out_data,
    input  logic       cfg_valid,
    output logic       cfg_ready,
    input  logic [1:0] cfg_index,
    input  logic [5:0] cfg_data
);

    cfg_t     cfg_reg, cfg_next;
    logic     in_valid_reg, in_valid_next;
    in_item_t in_data_reg;
    logic     step_ready;
    logic     end_valid;
    logic     end_ready;
    end_rec_t end_rec;

    assign cfg_ready = 1'b1;
    assign in_ready  = !in_valid_reg || step_ready;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                REG_RADIX:        cfg_next.radix        = cfg_data;
                REG_RESULT_WIDTH: cfg_next.result_width = cfg_data[1:0];
                default:          cfg_next = cfg_reg;
            endcase
        end
    end

    always_comb
    begin
        in_valid_next = in_valid_reg;
        if (step_ready)
        begin
            in_valid_next = 1'b0;
        end
        if (in_valid && in_ready)
        begin
            in_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.radix        <= RADIX_RESET;
            cfg_reg.result_width <= WIDTH_32;
            in_valid_reg         <= 1'b0;
        end
        else
        begin
            cfg_reg      <= cfg_next;
            in_valid_reg <= in_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            in_data_reg <= in_data;
        end
    end

    rip_step u_step (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg_reg),
        .item_valid (in_valid_reg),
        .item_ready (step_ready),
        .item       (in_data_reg),
        .end_valid  (end_valid),
        .end_ready  (end_ready),
        .end_rec    (end_rec)
    );

    rip_finish u_finish (
        .clk       (clk),
        .rst_n     (rst_n),
        .end_valid (end_valid),
        .end_ready (end_ready),
        .end_rec   (end_rec),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

`ifndef SYNTHESIS
    a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.parse_status != ST_OK |-> out_data.parsed_value == 64'sd0)
        else $error("non-zero value with error status");

    a_byte_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.parse_status == ST_OK && cfg_reg.result_width == WIDTH_8
        |-> out_data.parsed_value >= I8_MIN && out_data.parsed_value <= I8_MAX)
        else $error("byte result out of range");

    a_short_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.parse_status == ST_OK && cfg_reg.result_width == WIDTH_16
        |-> out_data.parsed_value >= I16_MIN && out_data.parsed_value <= I16_MAX)
        else $error("short result out of range");

    a_end_moves: assert property (@(posedge clk) disable iff (!rst_n)
        end_valid && end_ready |=> out_valid)
        else $error("ended string lost before output register");
`endif

endmodule

// ----- test/testbench.sv -----
`timescale 1ns / 100ps

module testbench;
    import rip_pkg::*;

    localparam int          SETTLE_CYCLES = 4;
    localparam int          NOT_A_DIGIT   = 64;
    localparam logic [20:0] MAX_CODE      = 21'h10FFFF;
    localparam longint      LOW64         = $signed(64'h8000_0000_0000_0000);
    localparam longint      HIGH64        = 64'sh7FFF_FFFF_FFFF_FFFF;

    typedef struct packed {
        logic [5:0]         radix;
        width_code_t        width;
        logic [20:0]        ch;
        logic               last;
        logic               empty;
        logic               typed;
        logic signed [63:0] value;
        status_t            status;
    } text_row_t;

    logic       clk       = 1'b0;
    logic       rst_n     = 1'b0;
    logic       in_valid  = 1'b0;
    logic       in_ready;
    in_item_t   in_data   = '0;
    logic       out_valid;
    logic       out_ready = 1'b0;
    out_item_t  out_data;
    logic       cfg_valid = 1'b0;
    logic       cfg_ready;
    reg_index_t cfg_index = REG_RADIX;
    logic [5:0] cfg_data  = '0;

    out_item_t   pending_results [$];
    int          fault_count  = 0;
    int          results_seen = 0;
    int          sent_items   = 0;
    bit          calm         = 1'b0;

    // register copies and the parse state of the string under way
    logic [5:0]  cur_radix     = RADIX_RESET;
    width_code_t cur_width     = WIDTH_32;
    longint      acc_neg       = 0;
    bit          minus_seen    = 1'b0;
    bit          at_start      = 1'b1;
    bit          digit_taken   = 1'b0;
    status_t     sticky_status = ST_OK;

    text_row_t script [29] = '{
        '{6'd10, WIDTH_32, "7",      1'b1, 1'b0, 1'b1, 64'sd7,    ST_OK},
        '{6'd10, WIDTH_32, 21'h0,    1'b0, 1'b1, 1'b1, 64'sd0,    ST_MALFORMED},
        '{6'd10, WIDTH_32, CH_MINUS, 1'b1, 1'b0, 1'b1, 64'sd0,    ST_MALFORMED},
        '{6'd10, WIDTH_32, CH_PLUS,  1'b0, 1'b0, 1'b0, 64'sd0,    ST_OK},
        '{6'd10, WIDTH_32, "z",      1'b1, 1'b0, 1'b1, 64'sd0,    ST_BAD_DIGIT},
        '{6'd10, WIDTH_32, " ",      1'b1, 1'b0, 1'b1, 64'sd0,    ST_MALFORMED},
        '{6'd10, WIDTH_32, MAX_CODE, 1'b1, 1'b0, 1'b1, 64'sd0,    ST_BAD_DIGIT},
        // byte range edges in hex, then a short out of range in radix 36
        '{6'd16, WIDTH_8,  CH_MINUS, 1'b0, 1'b0, 1'b0, 64'sd0,    ST_OK},
        '{6'd16, WIDTH_8,  "8",      1'b0, 1'b0, 1'b0, 64'sd0,    ST_OK},
        '{6'd16, WIDTH_8,  "0",      1'b1, 1'b0, 1'b1, -64'sd128, ST_OK},
        '{6'd16, WIDTH_8,  "8",      1'b0, 1'b0, 1'b0, 64'sd0,    ST_OK},
        '{6'd16, WIDTH_8,  "0",      1'b1, 1'b0, 1'b1, 64'sd0,    ST_RANGE},
        '{6'd36, WIDTH_16, "Z",      1'b0, 1'b0, 1'b0, 64'sd0,    ST_OK},
        '{6'd36, WIDTH_16, "Z",      1'b0, 1'b0, 1'b0, 64'sd0,    ST_OK},
        '{6'd36, WIDTH_16, "Z",      1'b1, 1'b0, 1'b1, 64'sd0,    ST_RANGE},
        // empty mark after digits just closes the string; then illegal radices
        '{6'd2,  WIDTH_32, "1",      1'b0, 1'b0, 1'b0, 64'sd0,    ST_OK},
        '{6'd2,  WIDTH_32, "0",      1'b0, 1'b0, 1'b0, 64'sd0,    ST_OK},
        '{6'd2,  WIDTH_32, 21'h0,    1'b0, 1'b1, 1'b1, 64'sd2,    ST_OK},
        '{6'd63, WIDTH_32, 21'h0,    1'b0, 1'b1, 1'b1, 64'sd0,    ST_BAD_RADIX},
        '{6'd0,  WIDTH_32, "5",      1'b1, 1'b0, 1'b1, 64'sd0,    ST_BAD_RADIX},
        // radix made illegal in the middle of a string
        '{6'd10, WIDTH_32, "4",      1'b0, 1'b0, 1'b0, 64'sd0,    ST_OK},
        '{6'd0,  WIDTH_32, "2",      1'b1, 1'b0, 1'b1, 64'sd0,    ST_BAD_RADIX},
        // 36^6 - 1 fits 64 bits, then the width drops to 32 before the end
        '{6'd36, WIDTH_64, "z",      1'b0, 1'b0, 1'b0, 64'sd0,    ST_OK},
        '{6'd36, WIDTH_64, "z",      1'b0, 1'b0, 1'b0, 64'sd0,    ST_OK},
        '{6'd36, WIDTH_64, "z",      1'b0, 1'b0, 1'b0, 64'sd0,    ST_OK},
        '{6'd36, WIDTH_64, "z",      1'b0, 1'b0, 1'b0, 64'sd0,    ST_OK},
        '{6'd36, WIDTH_64, "z",      1'b0, 1'b0, 1'b0, 64'sd0,    ST_OK},
        '{6'd36, WIDTH_64, "z",      1'b0, 1'b0, 1'b0, 64'sd0,    ST_OK},
        '{6'd36, WIDTH_32, 21'h0,    1'b0, 1'b1, 1'b1, 64'sd0,    ST_OVERFLOW}
    };

    radix_integer_parser dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic bit radix_legal();
        return cur_radix >= RADIX_MIN && cur_radix <= RADIX_MAX;
    endfunction

    task automatic take_char(input logic [20:0] c);
        bit     was_first;
        int     v;
        longint base;
        longint lim;
        longint mmin;
        was_first = at_start;
        at_start  = 1'b0;
        if (!radix_legal())
        begin
            sticky_status = ST_BAD_RADIX;
            return;
        end
        if (sticky_status != ST_OK)
            return;
        if (was_first && c < CH_ZERO)
        begin
            if (c == CH_MINUS)
                minus_seen = 1'b1;
            else if (c != CH_PLUS)
                sticky_status = ST_MALFORMED;
            return;
        end
        if (c >= "0" && c <= "9")
            v = int'(c - CH_ZERO);
        else if (c >= "a" && c <= "z")
            v = int'(c - "a") + 10;
        else if (c >= "A" && c <= "Z")
            v = int'(c - "A") + 10;
        else
            v = NOT_A_DIGIT;
        base = longint'(cur_radix);
        if (v >= base)
        begin
            sticky_status = ST_BAD_DIGIT;
            return;
        end
        // digits pile up below zero so the most negative value stays reachable
        if (cur_width == WIDTH_64)
            lim = minus_seen ? LOW64 : -HIGH64;
        else
            lim = minus_seen ? I32_MIN : -I32_MAX;
        mmin = lim / base;
        if (acc_neg < mmin)
        begin
            sticky_status = ST_OVERFLOW;
            return;
        end
        acc_neg = acc_neg * base;
        if (acc_neg < lim + v)
        begin
            sticky_status = ST_OVERFLOW;
            return;
        end
        acc_neg     = acc_neg - v;
        digit_taken = 1'b1;
    endtask

    task automatic predict(input in_item_t it, output bit produced, output out_item_t res);
        status_t st;
        longint  val;
        produced = 1'b0;
        res      = '0;
        if (!it.empty_text)
        begin
            take_char(it.char_code);
            if (!it.last_char)
                return;
        end
        st  = sticky_status;
        val = 0;
        if (!radix_legal())
            st = ST_BAD_RADIX;
        else if (st == ST_OK && !digit_taken)
            st = ST_MALFORMED;
        if (st == ST_OK)
        begin
            val = minus_seen ? acc_neg : -acc_neg;
            if (cur_width != WIDTH_64 && (val < I32_MIN || val > I32_MAX))
                st = ST_OVERFLOW;
            else if (cur_width == WIDTH_8 && (val < I8_MIN || val > I8_MAX))
                st = ST_RANGE;
            else if (cur_width == WIDTH_16 && (val < I16_MIN || val > I16_MAX))
                st = ST_RANGE;
        end
        if (st != ST_OK)
            val = 0;
        produced           = 1'b1;
        res.parsed_value   = val;
        res.parse_status   = st;
        acc_neg            = 0;
        minus_seen         = 1'b0;
        at_start           = 1'b1;
        digit_taken        = 1'b0;
        sticky_status      = ST_OK;
    endtask

    task automatic report_fault(input string msg);
        fault_count++;
        if (fault_count <= 10)
            $display("%s", msg);
    endtask

    task automatic push_char(input in_item_t it, input bit typed, input out_item_t typed_res);
        bit        produced;
        out_item_t res;
        while (!calm && $urandom_range(99) < 18)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= it;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        predict(it, produced, res);
        if (produced)
            pending_results.push_back(typed ? typed_res : res);
        sent_items++;
    endtask

    // registers change only with the block drained and the last character settled
    task automatic write_reg(input reg_index_t idx, input logic [5:0] val);
        in_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        if (idx == REG_RADIX)
            cur_radix = val;
        else if (idx == REG_RESULT_WIDTH)
            cur_width = width_code_t'(val[1:0]);
        cfg_valid <= 1'b0;
    endtask

    task automatic set_config(input logic [5:0] r, input width_code_t w);
        if (r != cur_radix)
            write_reg(REG_RADIX, r);
        if (w != cur_width)
            write_reg(REG_RESULT_WIDTH, {4'($urandom_range(15)), 2'(w)});
    endtask

    function automatic logic [5:0] pick_radix();
        int roll;
        roll = $urandom_range(99);
        if (roll < 80)
            return 6'($urandom_range(RADIX_MIN, RADIX_MAX));
        if (roll < 88)
            return $urandom_range(1) ? RADIX_MIN : RADIX_MAX;
        return 6'($urandom_range(1) ? $urandom_range(37, 63) : $urandom_range(0, 1));
    endfunction

    function automatic logic [20:0] digit_char(input int v);
        if (v < 10)
            return 21'(CH_ZERO + v);
        return 21'(($urandom_range(1) ? "a" : "A") + v - 10);
    endfunction

    function automatic logic [20:0] noise_char();
        case ($urandom_range(3))
            0: return 21'($urandom_range(0, MAX_CODE));
            1: return 21'($urandom_range(0, 127));
            2: return 21'($urandom_range(0, 21'hFFFF));
            default:
                // neighbours of the digit and letter ranges
                case ($urandom_range(5))
                    0: return 21'h2F;
                    1: return 21'h3A;
                    2: return 21'h40;
                    3: return 21'h5B;
                    4: return 21'h60;
                    default: return 21'h7B;
                endcase
        endcase
    endfunction

    function automatic longint edge_value();
        longint v;
        case ($urandom_range(17))
            0: v = 0;
            1: v = I8_MAX;
            2: v = I8_MAX + 1;
            3: v = I8_MIN;
            4: v = I8_MIN - 1;
            5: v = I16_MAX;
            6: v = I16_MAX + 1;
            7: v = I16_MIN;
            8: v = I16_MIN - 1;
            9: v = I32_MAX;
            10: v = I32_MAX + 1;
            11: v = I32_MIN;
            12: v = I32_MIN - 1;
            13: v = HIGH64;
            14: v = LOW64;
            15: v = longint'($signed($urandom));
            16: v = longint'($urandom_range(0, 1000));
            default: v = {$urandom, $urandom};
        endcase
        if ($urandom_range(1))
            v = v + $urandom_range(0, 4) - 2;
        return v;
    endfunction

    function automatic in_item_t plain_char(input logic [20:0] c);
        in_item_t it;
        it.char_code  = c;
        it.last_char  = 1'b0;
        it.empty_text = 1'b0;
        return it;
    endfunction

    task automatic send_text();
        in_item_t    chars [$];
        in_item_t    tail;
        int          digits [$];
        int          base;
        int          kind;
        int          n;
        int          cut;
        int          roll;
        longint      target;
        logic [63:0] mag;
        bit          neg;
        base = radix_legal() ? int'(cur_radix) : 10;
        kind = $urandom_range(99);
        if (kind < 45)
        begin
            roll = $urandom_range(9);
            n = roll < 6 ? $urandom_range(1, 4) :
                roll < 9 ? $urandom_range(5, 12) : $urandom_range(13, 66);
            case ($urandom_range(2))
                0: chars.push_back(plain_char(CH_MINUS));
                1: chars.push_back(plain_char(CH_PLUS));
                default: ;
            endcase
            repeat (n) chars.push_back(plain_char(digit_char($urandom_range(base - 1))));
        end
        else if (kind < 75)
        begin
            target = edge_value();
            neg    = target < 0;
            mag    = neg ? 64'(-target) : 64'(target);
            do
            begin
                digits.push_front(int'(mag % 64'(base)));
                mag = mag / 64'(base);
            end
            while (mag != 0);
            if ($urandom_range(9) == 0)
                repeat ($urandom_range(1, 3)) digits.push_front(0);
            // one digit more pushes a limit value over the edge
            if ($urandom_range(4) == 0)
                digits.push_back($urandom_range(base - 1));
            if (neg)
                chars.push_back(plain_char(CH_MINUS));
            else if ($urandom_range(3) == 0)
                chars.push_back(plain_char(CH_PLUS));
            foreach (digits[i])
                chars.push_back(plain_char(digit_char(digits[i])));
        end
        else
        begin
            case ($urandom_range(5))
                0: ;
                1: chars.push_back(plain_char($urandom_range(1) ? CH_MINUS : CH_PLUS));
                2: repeat ($urandom_range(1, 4)) chars.push_back(plain_char(noise_char()));
                3:
                begin
                    repeat ($urandom_range(1, 4))
                        chars.push_back(plain_char(digit_char($urandom_range(base - 1))));
                    if (base < 36 && $urandom_range(1))
                        chars.insert($urandom_range(chars.size()),
                                     plain_char(digit_char($urandom_range(base, 35))));
                    else
                        chars.insert($urandom_range(chars.size()), plain_char(noise_char()));
                end
                4:
                begin
                    repeat ($urandom_range(1, 3))
                        chars.push_back(plain_char(digit_char($urandom_range(base - 1))));
                    chars.push_back(plain_char($urandom_range(1) ? CH_MINUS : CH_PLUS));
                    repeat ($urandom_range(0, 2))
                        chars.push_back(plain_char(digit_char($urandom_range(base - 1))));
                end
                default:
                begin
                    chars.push_back(plain_char(noise_char()));
                    repeat ($urandom_range(0, 3))
                        chars.push_back(plain_char(digit_char($urandom_range(base - 1))));
                end
            endcase
        end
        if (chars.size() == 0 || $urandom_range(99) < 15)
        begin
            tail.char_code  = 21'($urandom_range(0, MAX_CODE));
            tail.last_char  = 1'($urandom_range(1));
            tail.empty_text = 1'b1;
            chars.push_back(tail);
        end
        else
            chars[chars.size() - 1].last_char = 1'b1;
        cut = -1;
        if (chars.size() > 1 && $urandom_range(99) < 4)
            cut = $urandom_range(1, chars.size() - 1);
        foreach (chars[i])
        begin
            if (i == cut)
            begin
                if ($urandom_range(1))
                    write_reg(REG_RADIX, pick_radix());
                else
                    write_reg(REG_RESULT_WIDTH, 6'($urandom_range(63)));
            end
            push_char(chars[i], 1'b0, '0);
        end
    endtask

    // result side: checks each transaction, idles at random, holds off once
    initial
    begin
        int        hold_left;
        bit        hold_done;
        out_item_t want;
        hold_left = 0;
        hold_done = 1'b0;
        forever
        begin
            @(posedge clk);
            if (out_valid && out_ready)
            begin
                results_seen++;
                if (pending_results.size() == 0)
                    report_fault($sformatf("unexpected result: value %0d status %0d",
                                           out_data.parsed_value, out_data.parse_status));
                else
                begin
                    want = pending_results.pop_front();
                    if (out_data.parsed_value !== want.parsed_value ||
                        out_data.parse_status !== want.parse_status)
                        report_fault($sformatf(
                            "result mismatch: expected value %0d status %0d, got value %0d status %0d",
                            want.parsed_value, want.parse_status,
                            out_data.parsed_value, out_data.parse_status));
                end
            end
            if (!hold_done && results_seen == 80)
            begin
                hold_done = 1'b1;
                hold_left = 400;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                out_ready <= 1'b0;
            end
            else
                out_ready <= calm || ($urandom_range(99) >= 18);
        end
    end

    initial
    begin
        #(5_000_000);
        $display("Verification failed");
        $finish;
    end

    initial
    begin
        in_item_t  it;
        out_item_t want;
        int        random_start;
        int        texts;
        int        wait_cycles;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        foreach (script[i])
        begin
            set_config(script[i].radix, script[i].width);
            it   = '{script[i].ch, script[i].last, script[i].empty};
            want = '{script[i].value, script[i].status};
            push_char(it, script[i].typed, want);
        end
        random_start = sent_items;
        texts        = 0;
        while (sent_items - random_start < 1900)
        begin
            calm = (sent_items - random_start >= 700) && (sent_items - random_start < 1000);
            if (texts % 25 == 0)
                set_config(pick_radix(), width_code_t'($urandom_range(3)));
            send_text();
            texts++;
        end
        in_valid <= 1'b0;
        for (wait_cycles = 0; pending_results.size() != 0 && wait_cycles < 20000;
             wait_cycles++)
            @(posedge clk);
        repeat (2 * SETTLE_CYCLES) @(posedge clk);
        if (pending_results.size() != 0)
            report_fault($sformatf("%0d results never arrived", pending_results.size()));
        if (fault_count == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
